[rtl/per_key_cooldown_limiter_core_assert.svh]
// Assertion macros shared by the limiter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PER_KEY_COOLDOWN_LIMITER_CORE_ASSERT_SVH
`define PER_KEY_COOLDOWN_LIMITER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PLC_ASSERT_HOLD(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define PLC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PLC_ASSERT_HOLD(label, clk, rst, cond)
`define PLC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PLC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/plc_pkg.sv]
// Shared types and constants of the cooldown limiter.
// Depends on nothing; imported by plc_scan, the top level and the testbench.
`timescale 1ns / 1ps

package plc_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W = 128;
   localparam int TIME_W = 32;
   localparam int COOL_W = 16;
   localparam logic [COOL_W-1:0] COOLDOWN_RESET = 16'd3;

   typedef struct packed {
      logic [63:0] client_address_high;
      logic [63:0] client_address_low;
      logic [31:0] now_seconds;
      logic        extend_on_deny;
   } req_type;

   typedef struct packed {
      logic admitted;
      logic newly_added;
      logic table_full;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TIME,
      ST_APPEND,
      ST_FINISH
   } scan_state_type;

   // Control from the top level to the table engine.
   typedef struct packed {
      logic              start;
      logic              stall;
      logic [COOL_W-1:0] cooldown;
      req_type           item;
   } scan_cmd_type;

   // Status from the table engine back to the top level.
   typedef struct packed {
      logic    done;
      rsp_type rsp;
   } scan_res_type;

endpackage

[rtl/plc_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the address and time tables.
`timescale 1ns / 1ps

module plc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/plc_scan.sv]
// Table engine: walks the address table, checks the cooldown and updates state.
// Depends on plc_pkg, plc_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "per_key_cooldown_limiter_core_assert.svh"

module plc_scan
   import plc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  scan_cmd_type cmd,
   output scan_res_type res
);

   scan_state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   rsp_type          rsp_ff, rsp_in;

   logic              addr_wr_en, addr_rd_en;
   logic [IDX_W-1:0]  addr_wr_addr, addr_rd_addr;
   logic [ADDR_W-1:0] addr_rd_data;
   logic              time_wr_en, time_rd_en;
   logic [IDX_W-1:0]  time_wr_addr;
   logic [TIME_W-1:0] time_rd_data;

   logic [ADDR_W-1:0] key;
   logic              hit;
   logic              last_entry;
   logic [TIME_W-1:0] elapsed;
   logic              cooling;
   logic              room;

   assign key        = {cmd.item.client_address_high, cmd.item.client_address_low};
   assign hit        = (addr_rd_data == key);
   assign last_entry = (CNT_W'({1'b0, idx_ff}) + CNT_W'(1)) == fill_ff;
   // The difference wraps modulo 2^32, so a clock that steps back reads as a long wait.
   assign elapsed    = cmd.item.now_seconds - time_rd_data;
   assign cooling    = elapsed < {{(TIME_W-COOL_W){1'b0}}, cmd.cooldown};
   assign room       = fill_ff < CNT_W'(TABLE_ENTRIES);

   plc_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_wr_en),
      .wr_addr (addr_wr_addr),
      .wr_data (key),
      .rd_en   (addr_rd_en),
      .rd_addr (addr_rd_addr),
      .rd_data (addr_rd_data)
   );

   plc_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES)) u_time_ram (
      .clock   (clock),
      .wr_en   (time_wr_en),
      .wr_addr (time_wr_addr),
      .wr_data (cmd.item.now_seconds),
      .rd_en   (time_rd_en),
      .rd_addr (idx_ff),
      .rd_data (time_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      rsp_in       = rsp_ff;
      addr_rd_en   = 1'b0;
      addr_rd_addr = idx_ff;
      addr_wr_en   = 1'b0;
      addr_wr_addr = fill_ff[IDX_W-1:0];
      time_rd_en   = 1'b0;
      time_wr_en   = 1'b0;
      time_wr_addr = idx_ff;
      res.done     = 1'b0;
      res.rsp      = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               idx_in = '0;
               if (fill_ff == '0) begin
                  state_in = ST_APPEND;
               end else begin
                  addr_rd_en   = 1'b1;
                  addr_rd_addr = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Stored addresses are unique, so the first match is the only one.
            if (hit) begin
               time_rd_en = 1'b1;
               state_in   = ST_TIME;
            end else if (last_entry) begin
               state_in = ST_APPEND;
            end else begin
               idx_in       = idx_ff + IDX_W'(1);
               addr_rd_en   = 1'b1;
               addr_rd_addr = idx_ff + IDX_W'(1);
            end
         end
         ST_TIME: begin
            rsp_in.admitted    = !cooling;
            rsp_in.newly_added = 1'b0;
            rsp_in.table_full  = 1'b0;
            time_wr_en         = !cooling || cmd.item.extend_on_deny;
            state_in           = ST_FINISH;
         end
         ST_APPEND: begin
            rsp_in.admitted    = 1'b1;
            rsp_in.newly_added = 1'b1;
            rsp_in.table_full  = !room;
            if (room) begin
               addr_wr_en   = 1'b1;
               time_wr_en   = 1'b1;
               time_wr_addr = fill_ff[IDX_W-1:0];
               fill_in      = fill_ff + CNT_W'(1);
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            res.done = 1'b1;
            if (!cmd.stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `PLC_ASSERT_HOLD(a_fill_bound, clock, reset, fill_ff <= CNT_W'(TABLE_ENTRIES))
   `PLC_ASSERT_IMPL(a_start_idle, clock, reset, cmd.start, state_ff == ST_IDLE)
   `PLC_ASSERT_NEXT(a_append_count, clock, reset, addr_wr_en,
                    fill_ff == $past(fill_ff) + CNT_W'(1))
   `PLC_ASSERT_IMPL(a_admit_renews, clock, reset,
                    state_ff == ST_TIME && !cooling, time_wr_en)

endmodule

[rtl/per_key_cooldown_limiter_core.sv]
// Top level of the per-client cooldown limiter: handshakes, register, result.
// Depends on plc_pkg and plc_scan (which holds the table RAMs).
//
// Usage: each request item on req_data (valid/ready) carries a 128-bit client
// address, the current time in seconds and an extend flag. One result item
// per request leaves on rsp_data (valid/ready): admitted, newly_added and
// table_full. csr_wdata sets the cooldown in seconds (reset value 3); write it
// only while no request is in flight. csr_ready is always high.
// The time from acceptance to result is set by the table walk, which reads one
// stored address per cycle from the address RAM and stops at the first match; a
// new table (fill_count zero) skips the walk. The table holds 256 entries. One
// item is worked on at a time; the next can be accepted in the cycle after the
// previous result is registered, even while that result still waits on rsp_ready.
// Reset clears the fill count, so the table starts empty and the block is
// ready at once. While the receiver stalls, a finished item waits in the
// engine and the next one is not accepted until the output register frees.
`timescale 1ns / 1ps

module per_key_cooldown_limiter_core
   import plc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [COOL_W-1:0] csr_wdata
);

   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   req_type           req_ff, req_in;
   logic [COOL_W-1:0] cooldown_ff, cooldown_in;

   logic         accept;
   logic         stall;
   logic         deliver;
   scan_cmd_type cmd;
   scan_res_type res;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign stall     = rsp_valid_ff && !rsp_ready;
   assign deliver   = res.done && !stall;
   assign csr_ready = 1'b1;

   assign cmd.start    = accept;
   assign cmd.stall    = stall;
   assign cmd.cooldown = cooldown_ff;
   // The engine starts in the cycle after acceptance, reading the held item.
   assign cmd.item     = req_ff;

   plc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_in       = req_ff;
      cooldown_in  = cooldown_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (deliver) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res.rsp;
         busy_in      = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         req_in  = req_data;
      end
      if (csr_valid && csr_ready) begin
         cooldown_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cooldown_ff  <= COOLDOWN_RESET;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         cooldown_ff  <= cooldown_in;
      end
      rsp_ff <= rsp_in;
      req_ff <= req_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[test/testbench.sv]
// Self-checking testbench for per_key_cooldown_limiter_core: directed and random requests.
// Depends on plc_pkg and the limiter RTL; predicts each result with its own table model.
`timescale 1ns / 1ps

module testbench;
   import plc_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int LONG_HOLD = 2000;
   localparam int DRAIN_CYCLES = 300;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_ITEMS = 96;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [COOL_W-1:0] csr_wdata = '0;

   // Model of the address table, its stored times and the cooldown register.
   logic [63:0]       key_high_table [TABLE_ENTRIES];
   logic [63:0]       key_low_table [TABLE_ENTRIES];
   logic [31:0]       stamp_table [TABLE_ENTRIES];
   int unsigned       entry_count = 0;
   logic [COOL_W-1:0] cooldown_model = COOLDOWN_RESET;

   req_type           request_queue [$];
   rsp_type           verdict_queue [$];
   logic [127:0]      key_pool [$];
   logic [31:0]       wall_time = '0;

   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;
   int                hold_trigger = 0;
   int                hold_ack = 0;
   int                rsp_hold_left = 0;
   int                fail_count = 0;
   int                cycle_count = 0;

   logic [COOL_W-1:0] cooldown_plan [PHASE_COUNT] = '{
      16'd3, 16'd0, 16'd65535, 16'd1, 16'd5, 16'd12,
      16'd2, 16'd65534, 16'd8, 16'd20, 16'd40000, 16'd3
   };

   per_key_cooldown_limiter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Looks the address up, updates the model table and returns the verdict.
   function automatic rsp_type judge_request(req_type r);
      rsp_type     verdict;
      int unsigned slot;
      bit          hit;
      logic [31:0] elapsed;
      verdict = '0;
      slot = 0;
      hit = 1'b0;
      for (int unsigned i = 0; i < entry_count; i++) begin
         if (key_high_table[i] == r.client_address_high &&
             key_low_table[i] == r.client_address_low) begin
            slot = i;
            hit = 1'b1;
         end
      end
      if (!hit) begin
         verdict.admitted = 1'b1;
         verdict.newly_added = 1'b1;
         if (entry_count < TABLE_ENTRIES) begin
            key_high_table[entry_count] = r.client_address_high;
            key_low_table[entry_count] = r.client_address_low;
            stamp_table[entry_count] = r.now_seconds;
            entry_count++;
         end else begin
            verdict.table_full = 1'b1;
         end
      end else begin
         elapsed = r.now_seconds - stamp_table[slot];
         if (elapsed < {16'd0, cooldown_model}) begin
            if (r.extend_on_deny) stamp_table[slot] = r.now_seconds;
         end else begin
            stamp_table[slot] = r.now_seconds;
            verdict.admitted = 1'b1;
         end
      end
      return verdict;
   endfunction

   task automatic add_request(input logic [127:0] key, input logic [31:0] stamp,
                              input logic extend);
      req_type r;
      r.client_address_high = key[127:64];
      r.client_address_low = key[63:0];
      r.now_seconds = stamp;
      r.extend_on_deny = extend;
      request_queue.push_back(r);
   endtask

   // Returns at a falling edge once every item has been sent and answered.
   task automatic wait_drained();
      @(negedge clock);
      while (request_queue.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_cooldown(input logic [COOL_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      cooldown_model = value;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Random requests: a mix of fresh addresses, near misses of stored ones and repeats.
   task automatic run_random(input int count, input int fresh_pct);
      logic [127:0] key;
      int           roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (key_pool.size() == 0 || roll < fresh_pct) begin
            if (key_pool.size() != 0 && $urandom_range(99) < 15)
               key = key_pool[$urandom_range(key_pool.size() - 1)] ^
                     (128'd1 << $urandom_range(127));
            else
               key = {$urandom, $urandom, $urandom, $urandom};
            key_pool.push_back(key);
         end else if ($urandom_range(1) == 0) begin
            key = key_pool[key_pool.size() - 1 - $urandom_range(
                  key_pool.size() < 8 ? key_pool.size() - 1 : 7)];
         end else begin
            key = key_pool[$urandom_range(key_pool.size() - 1)];
         end
         roll = $urandom_range(99);
         if (roll < 3)
            wall_time = $urandom;
         else if (roll < 5)
            wall_time = wall_time - $urandom_range(1, 5);
         else
            wall_time = wall_time + $urandom_range(0, 3);
         add_request(key, wall_time, $urandom_range(1));
      end
   endtask

   // Sender: the prediction is made at the edge that accepts the item.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && req_ready) verdict_queue.push_back(judge_request(req_data));
         if (!req_valid || req_ready) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= request_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, armed from the main sequence.
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold_left <= 0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (hold_trigger != hold_ack) begin
         rsp_hold_left <= LONG_HOLD;
         hold_ack <= hold_trigger;
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type wanted;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $error("result item with no request outstanding");
               fail_count++;
            end else begin
               wanted = verdict_queue.pop_front();
               if (rsp_data.admitted !== wanted.admitted) begin
                  $error("admitted: expected %0b, actual %0b",
                         wanted.admitted, rsp_data.admitted);
                  fail_count++;
               end
               if (rsp_data.newly_added !== wanted.newly_added) begin
                  $error("newly_added: expected %0b, actual %0b",
                         wanted.newly_added, rsp_data.newly_added);
                  fail_count++;
               end
               if (rsp_data.table_full !== wanted.table_full) begin
                  $error("table_full: expected %0b, actual %0b",
                         wanted.table_full, rsp_data.table_full);
                  fail_count++;
               end
            end
         end
         rsp_ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : main_sequence
      logic [127:0] zero_key;
      logic [127:0] ones_key;
      logic [127:0] split_high_key;
      logic [127:0] split_low_key;
      logic [127:0] lsb_key;
      logic [127:0] msb_key;
      zero_key = '0;
      ones_key = '1;
      split_high_key = {64'hFFFF_FFFF_FFFF_FFFF, 64'd0};
      split_low_key = {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
      lsb_key = 128'd1;
      msb_key = {1'b1, 127'd0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset cooldown of three: refusal, renewal on refusal, exact boundary,
      // time stepping back and a wrap of the time count.
      add_request(zero_key, 32'd0, 1'b0);
      add_request(zero_key, 32'd1, 1'b0);
      add_request(zero_key, 32'd2, 1'b1);
      add_request(zero_key, 32'd4, 1'b0);
      add_request(zero_key, 32'd5, 1'b0);
      add_request(zero_key, 32'd4, 1'b0);
      add_request(ones_key, 32'hFFFF_FFFF, 1'b1);
      add_request(ones_key, 32'd1, 1'b0);
      add_request(ones_key, 32'd2, 1'b0);
      add_request(split_high_key, 32'd100, 1'b0);
      add_request(split_low_key, 32'd100, 1'b0);
      add_request(lsb_key, 32'd100, 1'b0);
      add_request(msb_key, 32'd100, 1'b0);
      add_request(lsb_key, 32'd101, 1'b1);
      add_request(zero_key, 32'd6, 1'b0);
      wait_drained();

      // With no cooldown every known address is let through.
      write_cooldown(16'd0);
      add_request(zero_key, 32'd6, 1'b0);
      add_request(ones_key, 32'd2, 1'b1);
      wait_drained();

      write_cooldown(16'hFFFF);
      add_request(split_high_key, 32'd100 + 32'd65534, 1'b0);
      add_request(split_high_key, 32'd100 + 32'd65535, 1'b0);
      add_request(split_low_key, 32'd100 + 32'd65535, 1'b1);
      add_request(split_low_key, 32'd100, 1'b1);
      add_request(msb_key, 32'd100 + 32'd65000, 1'b1);
      wait_drained();

      wall_time = 32'd1000;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_cooldown(phase == 6 ? 16'($urandom) : cooldown_plan[phase]);
         case (phase % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 69;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 69;
            end
            default: begin
               sender_idle_pct = 7;
               receiver_stall_pct = 7;
            end
         endcase
         // The sender keeps offering while the receiver holds off, so the
         // block fills up and stops taking items.
         if (phase == 4) hold_trigger++;
         run_random(PHASE_ITEMS, 35);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[per_key_cooldown_limiter_core.f]
+incdir+rtl
rtl/plc_pkg.sv
rtl/plc_ram.sv
rtl/plc_scan.sv
rtl/per_key_cooldown_limiter_core.sv
test/testbench.sv
